// ===== rtl/ultrasonic_ping_ranger_assert.svh =====
// Assertion macros shared by the ultrasonic ping ranger RTL.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef ULTRASONIC_PING_RANGER_ASSERT_SVH
`define ULTRASONIC_PING_RANGER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define UPR_ASSERT_SAME(lbl, ck, rs, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |-> (cons)) \
    else $error("upr assertion failed");

// The consequence must hold in the cycle after the condition.
`define UPR_ASSERT_NEXT(lbl, ck, rs, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (cons)) \
    else $error("upr assertion failed");

`endif

// ===== rtl/upr_pkg.sv =====
package upr_pkg;

  // Field widths.
  localparam int TRIG_WIDTH   = 8;
  localparam int HOLD_WIDTH   = 12;
  localparam int BLANK_WIDTH  = 10;
  localparam int TIMER_WIDTH  = 12;
  localparam int CM_WIDTH     = 11;
  localparam int REM_WIDTH    = 6;
  localparam int PADDR_WIDTH  = 4;
  localparam int PDATA_WIDTH  = 32;

  // Register reset values.
  localparam logic [TRIG_WIDTH-1:0]  TRIG_RESET  = 8'd15;
  localparam logic [HOLD_WIDTH-1:0]  HOLD_RESET  = 12'd400;
  localparam logic [BLANK_WIDTH-1:0] BLANK_RESET = 10'd80;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TRIGGER = 2'd0;
  localparam logic [1:0] REG_HOLDOFF = 2'd1;
  localparam logic [1:0] REG_BLANK   = 2'd2;

  // Action codes.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Sensor codes.
  localparam logic [1:0] SENSOR_LEFT   = 2'd0;
  localparam logic [1:0] SENSOR_MIDDLE = 2'd1;
  localparam logic [1:0] SENSOR_RIGHT  = 2'd2;
  localparam logic [1:0] SENSOR_IDLE   = 2'd3;

  // Echo microseconds per centimeter, and the distance ceiling.
  localparam int CM_DIVISOR = 58;
  localparam logic [REM_WIDTH-1:0] REM_LAST = REM_WIDTH'(CM_DIVISOR - 1);
  localparam logic [CM_WIDTH-1:0]  DIST_MAX = '1;

  typedef struct packed {
    logic [TRIG_WIDTH-1:0]  trigger_ticks;
    logic [HOLD_WIDTH-1:0]  holdoff_ticks;
    logic [BLANK_WIDTH-1:0] blank_ticks;
  } upr_cfg_t;

  typedef struct packed {
    logic       action;
    logic [1:0] start_sensor;
    logic [2:0] echo_levels;
  } upr_item_t;

  typedef struct packed {
    logic [2:0]          pin_drive_enable;
    logic                pin_level;
    logic [1:0]          active_sensor;
    logic [CM_WIDTH-1:0] left_cm;
    logic [CM_WIDTH-1:0] middle_cm;
    logic [CM_WIDTH-1:0] right_cm;
    logic                sweep_done;
    logic                busy_res;
  } upr_result_t;

endpackage

// ===== rtl/upr_regs.sv =====
module upr_regs
  import upr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready,
  output upr_cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= TRIG_RESET;
      cfg.holdoff_ticks <= HOLD_RESET;
      cfg.blank_ticks   <= BLANK_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_TRIGGER: cfg.trigger_ticks <= pwdata[TRIG_WIDTH-1:0];
        REG_HOLDOFF: cfg.holdoff_ticks <= pwdata[HOLD_WIDTH-1:0];
        REG_BLANK:   cfg.blank_ticks   <= pwdata[BLANK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_TRIGGER: prdata = PDATA_WIDTH'(cfg.trigger_ticks);
      REG_HOLDOFF: prdata = PDATA_WIDTH'(cfg.holdoff_ticks);
      REG_BLANK:   prdata = PDATA_WIDTH'(cfg.blank_ticks);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ultrasonic_ping_ranger.sv =====
// Ultrasonic ping ranger: sequences three single-pin ultrasonic sensors (left, middle,
// right). A start word names the first sensor and is ignored while a sweep runs; every
// other word is a one-microsecond tick carrying the three sampled echo pins. For each
// sensor the pin is driven high for trigger_ticks, low for holdoff_ticks, then released;
// the echo pulse is timed with a saturating COUNT_WIDTH-bit counter, the echo level is
// ignored for blank_ticks after the rise, and the distance in centimeters (count / 58,
// capped at 2047) is kept per sensor. There is no echo timeout. The block takes one word
// per clock unless stalled and returns exactly one result word per input word; the whole
// per-word state update is a single registered step, so that step is what sets the rate.
// An output register holds the result, and a new word is taken in the same cycle the held
// result is taken. The divide by 58 is never done as such: a remainder counter modulo 58
// and a centimeter counter run alongside the echo counter. Registers sit at byte
// addresses 0, 4 and 8 of the APB port, to be written by the user only while no word is
// in flight (unenforced). A write during a sweep takes effect from the next tick on.
module ultrasonic_ping_ranger
  import upr_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input channel.
  input  logic                   item_valid,
  output logic                   item_stall,
  input  upr_item_t              item,
  // Result channel.
  output logic                   result_valid,
  input  logic                   result_stall,
  output upr_result_t            result,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready
);

`include "ultrasonic_ping_ranger_assert.svh"

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_HOLD,
    PH_RISE,
    PH_BLANK,
    PH_FALL
  } phase_t;

  upr_cfg_t cfg;

  upr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer state.
  phase_t                 phase, phase_next;
  logic [1:0]             sensor, sensor_next;
  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic [COUNT_WIDTH-1:0] echo_count, echo_count_next;
  logic [REM_WIDTH-1:0]   cm_rem, cm_rem_next;
  logic [CM_WIDTH-1:0]    cm, cm_next;
  logic [CM_WIDTH-1:0]    left_cm, left_cm_next;
  logic [CM_WIDTH-1:0]    middle_cm, middle_cm_next;
  logic [CM_WIDTH-1:0]    right_cm, right_cm_next;
  logic                   result_valid_next;
  upr_result_t            result_next;

  logic                   accept;
  logic                   done;
  logic                   lvl;
  logic [TIMER_WIDTH-1:0] timer_inc;
  logic                   count_full;
  logic [COUNT_WIDTH-1:0] count_plus;
  logic [REM_WIDTH-1:0]   rem_plus;
  logic [CM_WIDTH-1:0]    cm_plus;
  logic                   busy_next;

  // The result register is free when empty or when its word leaves this cycle.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    case (sensor)
      SENSOR_LEFT:   lvl = item.echo_levels[0];
      SENSOR_MIDDLE: lvl = item.echo_levels[1];
      SENSOR_RIGHT:  lvl = item.echo_levels[2];
      default:       lvl = 1'b0;
    endcase
  end

  assign timer_inc = timer + TIMER_WIDTH'(1);

  // One microsecond of echo: the counter saturates, and the remainder and
  // centimeter counters only move when the echo counter moves, so cm always
  // equals echo_count / 58, capped at the distance ceiling.
  assign count_full = (echo_count == '1);
  assign count_plus = count_full ? echo_count : echo_count + COUNT_WIDTH'(1);

  always_comb begin
    rem_plus = cm_rem;
    cm_plus  = cm;
    if (!count_full) begin
      if (cm_rem == REM_LAST) begin
        rem_plus = '0;
        if (cm != DIST_MAX) begin
          cm_plus = cm + CM_WIDTH'(1);
        end
      end else begin
        rem_plus = cm_rem + REM_WIDTH'(1);
      end
    end
  end

  always_comb begin
    phase_next      = phase;
    sensor_next     = sensor;
    timer_next      = timer;
    echo_count_next = echo_count;
    cm_rem_next     = cm_rem;
    cm_next         = cm;
    left_cm_next    = left_cm;
    middle_cm_next  = middle_cm;
    right_cm_next   = right_cm;
    done            = 1'b0;

    if (item.action == ACT_START) begin
      if (phase == PH_IDLE && item.start_sensor != SENSOR_IDLE) begin
        sensor_next = item.start_sensor;
        phase_next  = PH_TRIG;
        timer_next  = '0;
      end
    end else begin
      case (phase)
        PH_TRIG: begin
          timer_next = timer_inc;
          if (timer_inc >= TIMER_WIDTH'(cfg.trigger_ticks)) begin
            timer_next = '0;
            phase_next = (cfg.holdoff_ticks == '0) ? PH_RISE : PH_HOLD;
          end
        end
        PH_HOLD: begin
          timer_next = timer_inc;
          if (timer_inc >= cfg.holdoff_ticks) begin
            timer_next = '0;
            phase_next = PH_RISE;
          end
        end
        PH_RISE: begin
          if (lvl) begin
            echo_count_next = '0;
            cm_rem_next     = '0;
            cm_next         = '0;
            timer_next      = '0;
            phase_next      = (cfg.blank_ticks == '0) ? PH_FALL : PH_BLANK;
          end
        end
        PH_BLANK: begin
          echo_count_next = count_plus;
          cm_rem_next     = rem_plus;
          cm_next         = cm_plus;
          timer_next      = timer_inc;
          if (timer_inc >= TIMER_WIDTH'(cfg.blank_ticks)) begin
            timer_next = '0;
            phase_next = PH_FALL;
          end
        end
        PH_FALL: begin
          echo_count_next = count_plus;
          cm_rem_next     = rem_plus;
          cm_next         = cm_plus;
          if (!lvl) begin
            // Echo has ended: store this sensor and move along the sweep.
            case (sensor)
              SENSOR_LEFT:   left_cm_next   = cm_plus;
              SENSOR_MIDDLE: middle_cm_next = cm_plus;
              default:       right_cm_next  = cm_plus;
            endcase
            timer_next = '0;
            if (sensor == SENSOR_RIGHT) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              sensor_next = sensor + 2'd1;
              phase_next  = PH_TRIG;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The result word reports the state after this word.
  always_comb begin
    busy_next = (phase_next != PH_IDLE);
    result_next.pin_drive_enable = '0;
    if (phase_next == PH_TRIG || phase_next == PH_HOLD) begin
      case (sensor_next)
        SENSOR_LEFT:   result_next.pin_drive_enable = 3'b001;
        SENSOR_MIDDLE: result_next.pin_drive_enable = 3'b010;
        SENSOR_RIGHT:  result_next.pin_drive_enable = 3'b100;
        default:       result_next.pin_drive_enable = 3'b000;
      endcase
    end
    result_next.pin_level     = (phase_next == PH_TRIG);
    result_next.active_sensor = busy_next ? sensor_next : SENSOR_IDLE;
    result_next.left_cm       = left_cm_next;
    result_next.middle_cm     = middle_cm_next;
    result_next.right_cm      = right_cm_next;
    result_next.sweep_done    = done;
    result_next.busy_res      = busy_next;
  end

  assign result_valid_next = accept || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sensor       <= SENSOR_LEFT;
      timer        <= '0;
      echo_count   <= '0;
      cm_rem       <= '0;
      cm           <= '0;
      left_cm      <= '0;
      middle_cm    <= '0;
      right_cm     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (accept) begin
        phase      <= phase_next;
        sensor     <= sensor_next;
        timer      <= timer_next;
        echo_count <= echo_count_next;
        cm_rem     <= cm_rem_next;
        cm         <= cm_next;
        left_cm    <= left_cm_next;
        middle_cm  <= middle_cm_next;
        right_cm   <= right_cm_next;
      end
    end
    if (accept) begin
      result <= result_next;
    end
  end

  // A start arriving mid-sweep must leave the phase alone.
  `UPR_ASSERT_NEXT(a_start_ignored_busy, clk, rst, accept && item.action == ACT_START && phase != PH_IDLE, phase == $past(phase))
  // The centimeter remainder never reaches the divisor.
  `UPR_ASSERT_SAME(a_rem_range, clk, rst, 1'b1, cm_rem <= REM_LAST)
  // A finished sweep is reported as idle.
  `UPR_ASSERT_SAME(a_done_idle, clk, rst, result_valid && result.sweep_done, !result.busy_res && result.active_sensor == SENSOR_IDLE)
  // A driven-high pin is always exactly one pin.
  `UPR_ASSERT_SAME(a_level_onehot, clk, rst, result_valid && result.pin_level, $onehot(result.pin_drive_enable))

endmodule
